// ===== src/framed_command_stepper_controller_assert.svh =====
// Assertion macros for the framed command stepper controller.
// FCS_ASSERT checks an implication in the same cycle.
// FCS_ASSERT_NXT checks an implication in the next cycle.
`ifndef FRAMED_COMMAND_STEPPER_CONTROLLER_ASSERT_SVH
`define FRAMED_COMMAND_STEPPER_CONTROLLER_ASSERT_SVH
`ifndef SYNTHESIS
`define FCS_ASSERT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fcs assertion failed");
`define FCS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fcs assertion failed");
`else
`define FCS_ASSERT(lbl, clk, rst_n, ante, cons)
`define FCS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/fcs_pkg.sv =====
// ----------------------------------------------------------------------------
// fcs_pkg
// Shared types, constants and helper functions of the stepper controller.
// ----------------------------------------------------------------------------
package fcs_pkg;

    localparam int MAX_FRAME_DEF   = 128;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [7:0] CH_STX   = 8'h02;
    localparam logic [7:0] CH_ETX   = 8'h03;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ACK   = 8'h38;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_FWD   = 8'h46;
    localparam logic [7:0] CH_STOP  = 8'h53;
    localparam logic [7:0] CH_UP    = 8'h55;
    localparam logic [7:0] CH_DOWN  = 8'h44;
    localparam logic [7:0] CH_INIT  = 8'h49;

    localparam int MIN_FRAME = 4;
    localparam int COLON_SAT = 5;

    // reply layout
    localparam int REPLY_IDX_W = 5;
    localparam logic [REPLY_IDX_W-1:0] REPLY_LAST = 5'd21;
    localparam logic [REPLY_IDX_W-1:0] REPLY_CSUM = 5'd17;

    // configuration register indexes
    localparam logic [2:0] CFG_PHASE_MODE  = 3'd0;
    localparam logic [2:0] CFG_NODE_ID     = 3'd1;
    localparam logic [2:0] CFG_RELOAD_MIN  = 3'd2;
    localparam logic [2:0] CFG_RELOAD_MAX  = 3'd3;
    localparam logic [2:0] CFG_RELOAD_STEP = 3'd4;

    localparam logic [1:0] MODE_ONE  = 2'd0;
    localparam logic [1:0] MODE_TWO  = 2'd1;
    localparam logic [1:0] MODE_HALF = 2'd2;

    localparam logic [7:0] RELOAD_RST = 8'd230;

    localparam logic [7:0] TBL_ONE  [8] = '{8'h08, 8'h04, 8'h02, 8'h01,
                                           8'h08, 8'h04, 8'h02, 8'h01};
    localparam logic [7:0] TBL_TWO  [8] = '{8'h0C, 8'h06, 8'h03, 8'h09,
                                           8'h0C, 8'h06, 8'h03, 8'h09};
    localparam logic [7:0] TBL_HALF [8] = '{8'h98, 8'h1C, 8'h34, 8'h26,
                                           8'h62, 8'h43, 8'hC1, 8'h89};

    typedef struct packed {
        logic [1:0] phase_mode;
        logic [7:0] node_id;
        logic [7:0] reload_min;
        logic [7:0] reload_max;
        logic [7:0] reload_step;
    } t_cfg;

    // work handed from front to back: a coil beat or a full reply
    typedef struct packed {
        logic        is_phase;
        logic [7:0]  id;
        logic [31:0] data;
    } t_cmd;

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        if (v < 4'd10) begin
            return 8'h30 + {4'd0, v};
        end
        return 8'h37 + {4'd0, v};
    endfunction

    function automatic logic [7:0] phase_pattern(input logic [1:0] mode,
                                                 input logic [2:0] idx);
        case (mode)
            MODE_ONE:  return TBL_ONE[idx];
            MODE_HALF: return TBL_HALF[idx];
            default:   return TBL_TWO[idx];
        endcase
    endfunction

    function automatic logic [7:0] reply_byte(input logic [REPLY_IDX_W-1:0] idx,
                                              input logic [7:0] id,
                                              input logic [31:0] data,
                                              input logic [7:0] xsum);
        case (idx)
            5'd0:  return CH_STX;
            5'd2:  return id;
            5'd4:  return CH_ONE;
            5'd6:  return hex_digit(data[31:28]);
            5'd7:  return hex_digit(data[27:24]);
            5'd8:  return hex_digit(data[23:20]);
            5'd9:  return hex_digit(data[19:16]);
            5'd10: return hex_digit(data[15:12]);
            5'd11: return hex_digit(data[11:8]);
            5'd12: return hex_digit(data[7:4]);
            5'd13: return hex_digit(data[3:0]);
            5'd15: return CH_ACK;
            5'd17: return hex_digit(xsum[7:4]);
            5'd18: return hex_digit(xsum[3:0]);
            5'd20: return CH_ETX;
            5'd1, 5'd3, 5'd5, 5'd14, 5'd16, 5'd19, 5'd21: return CH_COLON;
            default: return 8'h00;
        endcase
    endfunction

endpackage

// ===== src/framed_command_stepper_controller.sv =====
// Path: work from an accepted beat goes through the work queue, then the output register.
// Throughput: one input beat per cycle while the 4-entry work queue has room;
//   the output side sends one beat per cycle while m_tready is high, a reply being 22 beats.
// Input ready drops only while the work queue is full.
// Reset: i_rst_n synchronous active low; parser (but for its pending fields), motor
//   state, queue pointers and configuration registers return to their initial values.
// ----------------------------------------------------------------------------
// framed_command_stepper_controller
// Framed serial command controller with stepper coil sequencing.
// ----------------------------------------------------------------------------
module framed_command_stepper_controller #(
    parameter int MAX_FRAME   = fcs_pkg::MAX_FRAME_DEF,
    parameter int QUEUE_DEPTH = fcs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] tx_byte, [15:8] phase
    output logic        m_tuser,   // [0] kind
    output logic        m_tlast
);
    import fcs_pkg::*;

    t_cfg r_cfg;
    t_cmd push_cmd, head_cmd;
    logic push, pop, full, empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_mode  <= MODE_TWO;
            r_cfg.node_id     <= CH_ONE;
            r_cfg.reload_min  <= 8'd150;
            r_cfg.reload_max  <= 8'd230;
            r_cfg.reload_step <= 8'd10;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PHASE_MODE:  r_cfg.phase_mode  <= i_cfg_data[1:0];
                CFG_NODE_ID:     r_cfg.node_id     <= i_cfg_data;
                CFG_RELOAD_MIN:  r_cfg.reload_min  <= i_cfg_data;
                CFG_RELOAD_MAX:  r_cfg.reload_max  <= i_cfg_data;
                CFG_RELOAD_STEP: r_cfg.reload_step <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign s_tready = !full;

    fcs_front #(
        .MAX_FRAME (MAX_FRAME)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_accept (s_tvalid && s_tready),
        .i_action (s_tuser),
        .i_byte   (s_tdata),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    fcs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_full  (full),
        .o_empty (empty)
    );

    fcs_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (head_cmd),
        .i_empty  (empty),
        .o_pop    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== src/fcs_front.sv =====
// ----------------------------------------------------------------------------
// fcs_front
// Frame parser, command decode, motor timer and step counter; queues work.
// ----------------------------------------------------------------------------
module fcs_front #(
    parameter int MAX_FRAME = fcs_pkg::MAX_FRAME_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  fcs_pkg::t_cfg i_cfg,
    input  logic          i_accept,
    input  logic          i_action,
    input  logic [7:0]    i_byte,
    output logic          o_push,
    output fcs_pkg::t_cmd o_cmd
);
    import fcs_pkg::*;

    localparam int BCW = $clog2(MAX_FRAME + 1);

    logic           r_in_frame, n_in_frame;
    logic [BCW-1:0] r_count, n_count;
    logic [7:0]     r_xor, n_xor;
    logic [7:0]     r_recent [3];
    logic [7:0]     n_recent [3];
    logic [2:0]     r_colon, n_colon;
    logic [7:0]     r_pend [4];
    logic [7:0]     n_pend [4];
    logic [7:0]     r_comm [4];
    logic [7:0]     n_comm [4];
    logic           r_running, n_running;
    logic [7:0]     r_reload, n_reload;
    logic [7:0]     r_timer, n_timer;
    logic [2:0]     r_pidx, n_pidx;
    logic [31:0]    r_steps, n_steps;

    logic           is_byte, start, overlong, is_etx, keep;
    logic [BCW-1:0] b_count;
    logic [7:0]     b_xor;
    logic [2:0]     b_colon;
    logic [7:0]     b_pend [4];
    logic [7:0]     sum;
    logic           sum_ok;
    logic [8:0]     up_sum;
    logic [1:0]     fld;

    assign is_byte  = i_accept && !i_action;
    assign start    = is_byte && !r_in_frame && (i_byte == CH_STX);
    assign overlong = r_count >= BCW'(MAX_FRAME);
    assign is_etx   = is_byte && r_in_frame && !overlong && (i_byte == CH_ETX);
    assign keep     = start || (is_byte && r_in_frame && !overlong && (i_byte != CH_ETX));
    assign sum      = r_xor ^ r_recent[0] ^ r_recent[1] ^ r_recent[2];
    assign sum_ok   = (hex_digit(sum[7:4]) == r_recent[2])
                   && (hex_digit(sum[3:0]) == r_recent[1]);
    assign up_sum   = {1'b0, r_reload} + {1'b0, i_cfg.reload_step};

    always_comb begin
        n_in_frame = r_in_frame;
        n_count    = r_count;
        n_xor      = r_xor;
        n_recent   = r_recent;
        n_colon    = r_colon;
        n_pend     = r_pend;
        n_comm     = r_comm;
        n_running  = r_running;
        n_reload   = r_reload;
        n_timer    = r_timer;
        n_pidx     = r_pidx;
        n_steps    = r_steps;
        o_push     = 1'b0;
        o_cmd      = '0;
        fld        = 2'd0;

        // a new frame starts from cleared parse state, pending fields from committed ones
        if (start) begin
            b_count = '0;
            b_xor   = '0;
            b_colon = '0;
            b_pend  = r_comm;
        end else begin
            b_count = r_count;
            b_xor   = r_xor;
            b_colon = r_colon;
            b_pend  = r_pend;
        end

        if (i_accept && i_action) begin
            if (r_running) begin
                if (r_timer != 8'hFF) begin
                    n_timer = r_timer + 8'd1;
                end else begin
                    n_timer            = r_reload;
                    n_pidx             = r_pidx + 3'd1;
                    n_steps            = r_steps + 32'd1;
                    o_push             = 1'b1;
                    o_cmd.is_phase     = 1'b1;
                    o_cmd.data         = {24'd0, phase_pattern(i_cfg.phase_mode, r_pidx)};
                end
            end
        end

        if (start) begin
            n_in_frame = 1'b1;
        end

        if (is_byte && r_in_frame && overlong) begin
            n_in_frame = 1'b0;
        end

        if (keep) begin
            n_count     = b_count + BCW'(1);
            n_xor       = b_xor ^ i_byte;
            n_recent[2] = start ? 8'h00 : r_recent[1];
            n_recent[1] = start ? 8'h00 : r_recent[0];
            n_recent[0] = i_byte;
            n_colon     = b_colon;
            n_pend      = b_pend;
            if (i_byte == CH_COLON) begin
                if (b_colon < 3'(COLON_SAT)) begin
                    n_colon = b_colon + 3'd1;
                end
            end else if (b_colon >= 3'd1 && b_colon <= 3'd4) begin
                fld         = 2'(b_colon - 3'd1);
                n_pend[fld] = i_byte;
            end
        end

        if (is_etx) begin
            n_in_frame = 1'b0;
            if (r_count >= BCW'(MIN_FRAME)) begin
                n_comm = r_pend;
                if (r_pend[0] == i_cfg.node_id && sum_ok) begin
                    if (r_pend[1] == CH_ONE) begin
                        if (r_pend[3] == CH_FWD) begin
                            n_running = 1'b1;
                        end else if (r_pend[3] == CH_STOP) begin
                            n_running = 1'b0;
                        end
                        if (r_pend[2] == CH_UP) begin
                            if (r_reload < i_cfg.reload_max) begin
                                n_reload = up_sum[8] ? 8'hFF : up_sum[7:0];
                            end else begin
                                n_reload = i_cfg.reload_max;
                            end
                        end else if (r_pend[2] == CH_DOWN) begin
                            if (r_reload > i_cfg.reload_min) begin
                                n_reload = (r_reload > i_cfg.reload_step)
                                         ? r_reload - i_cfg.reload_step : 8'h00;
                            end else begin
                                n_reload = i_cfg.reload_min;
                            end
                        end else if (r_pend[2] == CH_INIT) begin
                            n_reload = i_cfg.reload_min;
                        end
                    end
                    o_push         = 1'b1;
                    o_cmd.is_phase = 1'b0;
                    o_cmd.id       = i_cfg.node_id;
                    o_cmd.data     = r_steps;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_count    <= '0;
            r_xor      <= '0;
            r_recent   <= '{8'h00, 8'h00, 8'h00};
            r_colon    <= '0;
            r_comm     <= '{8'h00, CH_ZERO, 8'h00, 8'h00};
            r_running  <= 1'b0;
            r_reload   <= RELOAD_RST;
            r_timer    <= RELOAD_RST;
            r_pidx     <= '0;
            r_steps    <= '0;
        end else begin
            r_in_frame <= n_in_frame;
            r_count    <= n_count;
            r_xor      <= n_xor;
            r_recent   <= n_recent;
            r_colon    <= n_colon;
            r_comm     <= n_comm;
            r_running  <= n_running;
            r_reload   <= n_reload;
            r_timer    <= n_timer;
            r_pidx     <= n_pidx;
            r_steps    <= n_steps;
        end
    end

    // pending fields are reloaded from committed ones at every frame start
    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
    end

endmodule

// ===== src/fcs_queue.sv =====
`include "framed_command_stepper_controller_assert.svh"
// ----------------------------------------------------------------------------
// fcs_queue
// Short FIFO of work entries between the front and the back.
// ----------------------------------------------------------------------------
module fcs_queue #(
    parameter int DEPTH = fcs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  fcs_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output fcs_pkg::t_cmd o_cmd,
    output logic          o_full,
    output logic          o_empty
);
    import fcs_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wptr, n_wptr;
    logic [PW-1:0] r_rptr, n_rptr;
    logic [CW-1:0] r_count, n_count;

    assign o_full  = r_count == CW'(DEPTH);
    assign o_empty = r_count == '0;
    assign o_cmd   = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    `FCS_ASSERT(a_no_overflow, i_clk, i_rst_n, i_push, !o_full)
    `FCS_ASSERT(a_no_underflow, i_clk, i_rst_n, i_pop, !o_empty)
    `FCS_ASSERT_NXT(a_push_fills, i_clk, i_rst_n, i_push && !i_pop, !o_empty)

endmodule

// ===== src/fcs_back.sv =====
`include "framed_command_stepper_controller_assert.svh"
// ----------------------------------------------------------------------------
// fcs_back
// Drains the work queue: one beat per coil step, 22 beats per reply.
// ----------------------------------------------------------------------------
module fcs_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  fcs_pkg::t_cmd i_cmd,
    input  logic          i_empty,
    output logic          o_pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [15:0]   m_tdata,
    output logic          m_tuser,
    output logic          m_tlast
);
    import fcs_pkg::*;

    logic                   r_busy, n_busy;
    logic [REPLY_IDX_W-1:0] r_idx, n_idx;
    logic [7:0]             r_id, n_id;
    logic [31:0]            r_data, n_data;
    logic [7:0]             r_xor, n_xor;
    logic                   r_valid, n_valid;
    logic                   r_kind, n_kind;
    logic [7:0]             r_tx, n_tx;
    logic                   r_last, n_last;
    logic [7:0]             r_phase, n_phase;

    logic                   load;
    logic [7:0]             cur_byte;

    assign load     = !r_valid || m_tready;
    assign o_pop    = load && !r_busy && !i_empty;
    assign cur_byte = reply_byte(r_idx, r_id, r_data, r_xor);

    always_comb begin
        n_busy  = r_busy;
        n_idx   = r_idx;
        n_id    = r_id;
        n_data  = r_data;
        n_xor   = r_xor;
        n_valid = r_valid;
        n_kind  = r_kind;
        n_tx    = r_tx;
        n_last  = r_last;
        n_phase = r_phase;
        if (load) begin
            n_valid = 1'b0;
            if (r_busy) begin
                n_valid = 1'b1;
                n_kind  = 1'b0;
                n_tx    = cur_byte;
                n_phase = 8'h00;
                n_last  = r_idx == REPLY_LAST;
                n_idx   = r_idx + 5'd1;
                if (r_idx < REPLY_CSUM) begin
                    n_xor = r_xor ^ cur_byte;
                end
                if (r_idx == REPLY_LAST) begin
                    n_busy = 1'b0;
                end
            end else if (!i_empty) begin
                n_valid = 1'b1;
                n_last  = 1'b0;
                if (i_cmd.is_phase) begin
                    n_kind  = 1'b1;
                    n_tx    = 8'h00;
                    n_phase = i_cmd.data[7:0];
                end else begin
                    // first reply beat goes out while the rest is latched
                    n_kind  = 1'b0;
                    n_tx    = CH_STX;
                    n_phase = 8'h00;
                    n_busy  = 1'b1;
                    n_idx   = 5'd1;
                    n_id    = i_cmd.id;
                    n_data  = i_cmd.data;
                    n_xor   = CH_STX;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_id    <= n_id;
        r_data  <= n_data;
        r_xor   <= n_xor;
        r_kind  <= n_kind;
        r_tx    <= n_tx;
        r_last  <= n_last;
        r_phase <= n_phase;
    end

    assign m_tvalid = r_valid;
    assign m_tdata  = {r_phase, r_tx};
    assign m_tuser  = r_kind;
    assign m_tlast  = r_last;

    `FCS_ASSERT(a_idx_range, i_clk, i_rst_n, r_busy, r_idx >= 5'd1 && r_idx <= REPLY_LAST)
    `FCS_ASSERT(a_last_on_reply, i_clk, i_rst_n, r_valid && r_last, !r_kind && !r_busy)

endmodule
